// ----- rtl/sidac_pkg.sv -----
// Shared constants, types and state codes of the decimal ASCII converter.
`default_nettype none
package sidac_pkg;

  localparam int VALUE_BITS     = 32;
  // Decimal digits of the largest magnitude 2^(VALUE_BITS-1)
  localparam int DIGITS         = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int DIGIT_IDX_BITS = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int BCD_BITS       = DIGITS * 4;
  localparam int STEP_BITS      = 4;
  localparam int SHIFT_CYCLES   = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_BITS       = SHIFT_CYCLES * STEP_BITS;
  localparam int CNT_BITS       = (SHIFT_CYCLES > 1) ? $clog2(SHIFT_CYCLES) : 1;
  localparam int CHAR_BITS      = 7;
  localparam int FIFO_DEPTH     = 2;
  localparam int FIFO_PTR_BITS  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_BITS  = $clog2(FIFO_DEPTH + 1);

  localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 7'd48;
  localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 7'd45;

  typedef struct packed {
    logic                  neg;
    logic [VALUE_BITS-1:0] mag;
  } entry_t;

  typedef enum logic [1:0] {
    BACK_IDLE,
    BACK_CONV,
    BACK_SIGN,
    BACK_DIGIT
  } back_state_e;

endpackage
`default_nettype wire

// ----- rtl/sidac_front.sv -----
// Front end: accepts a request, splits it into sign and unsigned magnitude.
`default_nettype none
module sidac_front (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic [sidac_pkg::VALUE_BITS-1:0] value_i,
  input  wire logic                             fifo_full_i,
  output logic                                  fifo_push_o,
  output sidac_pkg::entry_t                     fifo_data_o
);

  logic              item_valid_q, item_valid_d;
  sidac_pkg::entry_t item_q, item_d;
  logic              accept;
  logic              xfer;

  assign xfer        = item_valid_q && !fifo_full_i;
  assign full        = item_valid_q && fifo_full_i;
  assign accept      = push && !full;
  assign fifo_push_o = xfer;
  assign fifo_data_o = item_q;

  always_comb begin
    item_d.neg = value_i[sidac_pkg::VALUE_BITS-1];
    // Unsigned magnitude: the most negative value maps to 2^(n-1) exactly
    item_d.mag = item_d.neg ? (~value_i + sidac_pkg::VALUE_BITS'(1)) : value_i;
    if (accept) begin
      item_valid_d = 1'b1;
    end else if (xfer) begin
      item_valid_d = 1'b0;
    end else begin
      item_valid_d = item_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/sidac_fifo.sv -----
// Short request queue between front end and converter.
`default_nettype none
module sidac_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire sidac_pkg::entry_t data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output sidac_pkg::entry_t      data_o
);

  sidac_pkg::entry_t                       mem_q [sidac_pkg::FIFO_DEPTH];
  logic [sidac_pkg::FIFO_PTR_BITS-1:0]     wr_ptr_q, wr_ptr_d;
  logic [sidac_pkg::FIFO_PTR_BITS-1:0]     rd_ptr_q, rd_ptr_d;
  logic [sidac_pkg::FIFO_CNT_BITS-1:0]     cnt_q, cnt_d;
  logic                                    do_push;
  logic                                    do_pop;

  assign full_o  = (cnt_q == sidac_pkg::FIFO_CNT_BITS'(sidac_pkg::FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == sidac_pkg::FIFO_PTR_BITS'(sidac_pkg::FIFO_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == sidac_pkg::FIFO_PTR_BITS'(sidac_pkg::FIFO_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= sidac_pkg::FIFO_CNT_BITS'(sidac_pkg::FIFO_DEPTH))
    else $error("queue count above depth");

endmodule
`default_nettype wire

// ----- rtl/sidac_back.sv -----
// Converter: shift-add-3 to BCD, then emit sign and digits through an output register.
`default_nettype none
module sidac_back (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              fifo_valid_i,
  input  wire sidac_pkg::entry_t                 fifo_data_i,
  output logic                                   fifo_pop_o,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic [sidac_pkg::CHAR_BITS-1:0]        character_o,
  output logic                                   last_char_o
);

  sidac_pkg::back_state_e                  state_q, state_d;
  logic                                    neg_q, neg_d;
  logic [sidac_pkg::PAD_BITS-1:0]          shift_q, shift_d;
  logic [sidac_pkg::BCD_BITS-1:0]          bcd_q, bcd_d;
  logic [sidac_pkg::CNT_BITS-1:0]          cnt_q, cnt_d;
  logic [sidac_pkg::DIGIT_IDX_BITS-1:0]    idx_q, idx_d;
  logic [sidac_pkg::DIGIT_IDX_BITS-1:0]    lead_idx;
  logic                                    out_valid_q, out_valid_d;
  logic [sidac_pkg::CHAR_BITS-1:0]         char_q, char_d;
  logic                                    last_q, last_d;
  logic                                    slot_free;
  logic [3:0]                              cur_digit;
  logic [sidac_pkg::BCD_BITS-1:0]          dab_bcd;
  logic                                    bcd_ok;

  assign slot_free   = !out_valid_q || pop;
  assign empty       = !out_valid_q;
  assign character_o = char_q;
  assign last_char_o = last_q;
  assign cur_digit   = bcd_q[idx_q*4 +: 4];

  // Four shift-add-3 steps per cycle, top magnitude bits first
  always_comb begin
    dab_bcd = bcd_q;
    for (int s = 0; s < sidac_pkg::STEP_BITS; s++) begin
      for (int d = 0; d < sidac_pkg::DIGITS; d++) begin
        if (dab_bcd[d*4 +: 4] >= 4'd5) begin
          dab_bcd[d*4 +: 4] = dab_bcd[d*4 +: 4] + 4'd3;
        end
      end
      dab_bcd = {dab_bcd[sidac_pkg::BCD_BITS-2:0],
                 shift_q[sidac_pkg::PAD_BITS-1-s]};
    end
  end

  // Highest nonzero digit; zero keeps index 0
  always_comb begin
    lead_idx = '0;
    bcd_ok   = 1'b1;
    for (int d = 0; d < sidac_pkg::DIGITS; d++) begin
      if (bcd_q[d*4 +: 4] != 4'd0) begin
        lead_idx = sidac_pkg::DIGIT_IDX_BITS'(d);
      end
      if (bcd_q[d*4 +: 4] > 4'd9) begin
        bcd_ok = 1'b0;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    neg_d       = neg_q;
    shift_d     = shift_q;
    bcd_d       = bcd_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    fifo_pop_o  = 1'b0;
    out_valid_d = out_valid_q && !pop;
    char_d      = char_q;
    last_d      = last_q;
    case (state_q)
      sidac_pkg::BACK_IDLE: begin
        if (fifo_valid_i) begin
          fifo_pop_o = 1'b1;
          neg_d      = fifo_data_i.neg;
          shift_d    = sidac_pkg::PAD_BITS'(fifo_data_i.mag);
          bcd_d      = '0;
          cnt_d      = '0;
          state_d    = sidac_pkg::BACK_CONV;
        end
      end
      sidac_pkg::BACK_CONV: begin
        bcd_d   = dab_bcd;
        shift_d = shift_q << sidac_pkg::STEP_BITS;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == sidac_pkg::CNT_BITS'(sidac_pkg::SHIFT_CYCLES - 1)) begin
          state_d = sidac_pkg::BACK_SIGN;
        end
      end
      sidac_pkg::BACK_SIGN: begin
        idx_d = lead_idx;
        if (!neg_q) begin
          state_d = sidac_pkg::BACK_DIGIT;
        end else if (slot_free) begin
          out_valid_d = 1'b1;
          char_d      = sidac_pkg::CHAR_MINUS;
          last_d      = 1'b0;
          state_d     = sidac_pkg::BACK_DIGIT;
        end
      end
      sidac_pkg::BACK_DIGIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          char_d      = sidac_pkg::CHAR_ZERO + sidac_pkg::CHAR_BITS'(cur_digit);
          last_d      = (idx_q == '0);
          if (idx_q == '0) begin
            state_d = sidac_pkg::BACK_IDLE;
          end else begin
            idx_d = idx_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = sidac_pkg::BACK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sidac_pkg::BACK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q   <= neg_d;
    shift_q <= shift_d;
    bcd_q   <= bcd_d;
    cnt_q   <= cnt_d;
    idx_q   <= idx_d;
    char_q  <= char_d;
    last_q  <= last_d;
  end

  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (char_q == sidac_pkg::CHAR_MINUS ||
                     (char_q >= sidac_pkg::CHAR_ZERO && char_q <= 7'd57)))
    else $error("output character out of range");

  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && char_q == sidac_pkg::CHAR_MINUS) |-> !last_q)
    else $error("sign flagged as last character");

  a_bcd_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sidac_pkg::BACK_SIGN) |-> bcd_ok)
    else $error("BCD digit above nine after conversion");

  a_no_leading_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sidac_pkg::BACK_DIGIT && $past(state_q) == sidac_pkg::BACK_SIGN)
      |-> (idx_q == '0 || cur_digit != 4'd0))
    else $error("leading zero digit selected");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_pop_o |-> (state_q == sidac_pkg::BACK_IDLE))
    else $error("queue popped while converting");

endmodule
`default_nettype wire

// ----- rtl/signed_int_to_decimal_ascii_core.sv -----
// Top level of the signed integer to decimal ASCII converter.
//
//   channel   | handshake      | payload
//   ----------+----------------+----------------------------------
//   request   | push / full    | value_i (signed, VALUE_BITS)
//   character | empty / pop    | character_o (7 bits), last_char_o
//
// Each number leaves the queue, then goes through shift-add-3 conversion and
// the sign state, then the minus sign (negative values only) and the digits
// without leading zeros are emitted in order, held back while the output stalls.
// The front end and a two-entry queue take new requests while a number converts.
// Reset clears all control state; nothing else needs clearing.
// A stalled character holds in the output register and stalls the converter.
`default_nettype none
module signed_int_to_decimal_ascii_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic [sidac_pkg::VALUE_BITS-1:0] value_i,
  output logic                                  empty,
  input  wire logic                             pop,
  output logic [sidac_pkg::CHAR_BITS-1:0]       character_o,
  output logic                                  last_char_o
);

  logic              fifo_full;
  logic              fifo_push;
  sidac_pkg::entry_t fifo_wdata;
  logic              fifo_valid;
  logic              fifo_pop;
  sidac_pkg::entry_t fifo_rdata;

  sidac_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .value_i     (value_i),
    .fifo_full_i (fifo_full),
    .fifo_push_o (fifo_push),
    .fifo_data_o (fifo_wdata)
  );

  sidac_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .data_i  (fifo_wdata),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .valid_o (fifo_valid),
    .data_o  (fifo_rdata)
  );

  sidac_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_valid_i (fifo_valid),
    .fifo_data_i  (fifo_rdata),
    .fifo_pop_o   (fifo_pop),
    .empty        (empty),
    .pop          (pop),
    .character_o  (character_o),
    .last_char_o  (last_char_o)
  );

endmodule
`default_nettype wire
